[rtl/core/ppt_pkg.sv]
`default_nettype none

package ppt_pkg;

	// Fixed-point format and derived widths
	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;            // coordinate and coefficient width
	localparam int PW        = 2 * CW;        // full product width
	localparam int SUM_W     = PW + 2;        // sum of three products and a translation term
	localparam int MAG_W     = PW;            // magnitude of a column sum
	localparam int NCOL      = 4;             // x, y, z, w
	localparam int NROW      = 3;             // rows multiplied by the point
	localparam int NOUT      = 3;             // divided coordinates
	localparam int DIV_STEPS = CW;            // one quotient bit per stage
	localparam int NREG      = 8;
	localparam int DW        = 64;
	localparam int AW        = 6;
	localparam int NST       = 4 + DIV_STEPS + 1;

	localparam logic [DW-1:0] ONE_LO = DW'(1) << FRAC_BITS;
	localparam logic [DW-1:0] ONE_HI = DW'(1) << (FRAC_BITS + CW);

	localparam logic [CW-1:0] POS_LIMIT = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] NEG_LIMIT = {1'b1, {(CW-1){1'b0}}};

	// Register indexes
	typedef enum logic [2:0] {
		REG_ROW0_COLS01 = 3'd0,
		REG_ROW0_COLS23 = 3'd1,
		REG_ROW1_COLS01 = 3'd2,
		REG_ROW1_COLS23 = 3'd3,
		REG_ROW2_COLS01 = 3'd4,
		REG_ROW2_COLS23 = 3'd5,
		REG_ROW3_COLS01 = 3'd6,
		REG_ROW3_COLS23 = 3'd7
	} reg_idx_t;

	// One divider lane: partial remainder, and a word that shifts dividend
	// bits out at the top while quotient bits shift in at the bottom
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [CW-1:0]    qw;
		logic             ovf;
		logic             neg;
	} lane_t;

	// Identity matrix at reset
	function automatic logic [DW-1:0] reset_value(input reg_idx_t idx);
		logic [DW-1:0] v;
		v = '0;
		unique case (idx)
			REG_ROW0_COLS01: v = ONE_LO;
			REG_ROW1_COLS01: v = ONE_HI;
			REG_ROW2_COLS23: v = ONE_LO;
			REG_ROW3_COLS23: v = ONE_HI;
			default:         v = '0;
		endcase
		return v;
	endfunction

	// One restoring division step
	function automatic lane_t div_step(input lane_t l, input logic [MAG_W-1:0] den);
		logic [MAG_W:0] t;
		lane_t          r;
		t = {l.rem, l.qw[CW-1]};
		r = l;
		r.qw = {l.qw[CW-2:0], 1'b0};
		if (t >= {1'b0, den}) begin
			t = t - {1'b0, den};
			r.qw[0] = 1'b1;
		end
		r.rem = t[MAG_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/projective_point_transform.sv]
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// point in  | in_valid / in_ready  | point_x, point_y, point_z
// result    | out_valid / out_ready| out_x, out_y, out_z, w_zero, saturated
// config    | APB psel/penable     | paddr, pwdata, prdata (8 x 64-bit matrix regs)
//
// One point per cycle unless the output stalls. Stages: products, column sums,
// magnitudes, overflow check, 32 divider stages (one quotient bit each) and the
// output register.
// Reset clears the valid bits and loads the identity matrix.
// Every stage holds its request only while the stage after it is full and
// stalled, so bubbles close up behind a stalled output.

module projective_point_transform (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [ppt_pkg::CW-1:0] point_x,
	input  wire logic signed [ppt_pkg::CW-1:0] point_y,
	input  wire logic signed [ppt_pkg::CW-1:0] point_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [ppt_pkg::CW-1:0]    out_x,
	output logic signed [ppt_pkg::CW-1:0]    out_y,
	output logic signed [ppt_pkg::CW-1:0]    out_z,
	output logic                             w_zero,
	output logic                             saturated,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ppt_pkg::AW-1:0]      paddr,
	input  wire logic [ppt_pkg::DW-1:0]      pwdata,
	output logic [ppt_pkg::DW-1:0]           prdata,
	output logic                             pready
);

	localparam int CW    = ppt_pkg::CW;
	localparam int FB    = ppt_pkg::FRAC_BITS;
	localparam int NST   = ppt_pkg::NST;
	localparam int STEPS = ppt_pkg::DIV_STEPS;

	// Configuration registers
	logic [ppt_pkg::DW-1:0] cfg_q [ppt_pkg::NREG];
	ppt_pkg::reg_idx_t      widx;
	logic                   wr_en;

	assign pready = 1'b1;
	assign widx   = ppt_pkg::reg_idx_t'(paddr[ppt_pkg::AW-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = cfg_q[paddr[ppt_pkg::AW-1:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppt_pkg::NREG; i++) begin
				cfg_q[i] <= ppt_pkg::reset_value(ppt_pkg::reg_idx_t'(i));
			end
		end else if (wr_en) begin
			cfg_q[widx] <= pwdata;
		end
	end

	// Unpack coefficients M[r][c]
	logic signed [CW-1:0] coef [4][ppt_pkg::NCOL];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < ppt_pkg::NCOL; c++) begin
				coef[r][c] = cfg_q[2*r + c/2][(c%2)*CW +: CW];
			end
		end
	end

	// Stage enables: a stage loads when empty or when the next one moves
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || out_ready;
		for (int k = NST-2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = NST-1; k >= 1; k--) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
		end
	end

	// Stage 1: products and translation terms
	logic signed [ppt_pkg::PW-1:0] prod_s1  [ppt_pkg::NCOL][ppt_pkg::NROW];
	logic signed [CW-1:0]          trans_s1 [ppt_pkg::NCOL];
	logic signed [CW-1:0]          pt       [ppt_pkg::NROW];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int c = 0; c < ppt_pkg::NCOL; c++) begin
				for (int r = 0; r < ppt_pkg::NROW; r++) begin
					prod_s1[c][r] <= pt[r] * coef[r][c];
				end
				trans_s1[c] <= coef[3][c];
			end
		end
	end

	// Stage 2: exact column sums
	logic signed [ppt_pkg::SUM_W-1:0] sum_s2 [ppt_pkg::NCOL];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int c = 0; c < ppt_pkg::NCOL; c++) begin
				sum_s2[c] <= ppt_pkg::SUM_W'(prod_s1[c][0])
					+ ppt_pkg::SUM_W'(prod_s1[c][1])
					+ ppt_pkg::SUM_W'(prod_s1[c][2])
					+ (ppt_pkg::SUM_W'(trans_s1[c]) <<< FB);
			end
		end
	end

	// Stage 3: sign and magnitude
	logic [ppt_pkg::MAG_W-1:0] mag_s3 [ppt_pkg::NCOL];
	logic [ppt_pkg::NCOL-1:0]  neg_s3;
	logic                      wzero_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int c = 0; c < ppt_pkg::NCOL; c++) begin
				neg_s3[c] <= sum_s2[c][ppt_pkg::SUM_W-1];
				mag_s3[c] <= sum_s2[c][ppt_pkg::SUM_W-1]
					? ppt_pkg::MAG_W'(-sum_s2[c]) : ppt_pkg::MAG_W'(sum_s2[c]);
			end
			wzero_s3 <= (sum_s2[3] == '0);
		end
	end

	// Stage 4 and divider stages: element k sits in stage 4+k
	ppt_pkg::lane_t            div_s   [STEPS+1][ppt_pkg::NOUT];
	logic [ppt_pkg::MAG_W-1:0] den_s   [STEPS+1];
	logic                      wzero_s [STEPS+1];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int c = 0; c < ppt_pkg::NOUT; c++) begin
				// quotient needs more than CW bits when num >= den * 2^(CW-FB)
				div_s[0][c].ovf <= ({(CW-FB)'(0), mag_s3[c]}
					>= {mag_s3[3], (CW-FB)'(0)});
				div_s[0][c].rem <= ppt_pkg::MAG_W'(mag_s3[c] >> (CW-FB));
				div_s[0][c].qw  <= {mag_s3[c][CW-FB-1:0], FB'(0)};
				div_s[0][c].neg <= neg_s3[c] ^ neg_s3[3];
			end
			den_s[0]   <= mag_s3[3];
			wzero_s[0] <= wzero_s3;
		end
		for (int k = 1; k <= STEPS; k++) begin
			if (en[3+k]) begin
				for (int c = 0; c < ppt_pkg::NOUT; c++) begin
					div_s[k][c] <= ppt_pkg::div_step(div_s[k-1][c], den_s[k-1]);
				end
				den_s[k]   <= den_s[k-1];
				wzero_s[k] <= wzero_s[k-1];
			end
		end
	end

	// Output stage: clamp, apply sign, force zero w
	logic [CW-1:0] res_q [ppt_pkg::NOUT];
	logic          wzero_q;
	logic          sat_q;
	logic [CW-1:0] res_d [ppt_pkg::NOUT];
	logic [ppt_pkg::NOUT-1:0] sat_d;

	always_comb begin
		logic [CW-1:0] q;
		logic [CW-1:0] lim;
		logic [CW-1:0] mag;
		for (int c = 0; c < ppt_pkg::NOUT; c++) begin
			q   = div_s[STEPS][c].qw;
			lim = div_s[STEPS][c].neg ? ppt_pkg::NEG_LIMIT : ppt_pkg::POS_LIMIT;
			sat_d[c] = div_s[STEPS][c].ovf || (q > lim);
			mag = sat_d[c] ? lim : q;
			res_d[c] = div_s[STEPS][c].neg ? (~mag + CW'(1)) : mag;
			if (wzero_s[STEPS]) begin
				res_d[c] = '0;
				sat_d[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			for (int c = 0; c < ppt_pkg::NOUT; c++) begin
				res_q[c] <= res_d[c];
			end
			wzero_q <= wzero_s[STEPS];
			sat_q   <= |sat_d;
		end
	end

	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign w_zero    = wzero_q;
	assign saturated = sat_q;

`ifndef ASSERT_OFF
	// zero w gives zero coordinates and no clamp
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> out_x == 0 && out_y == 0 && out_z == 0 && !saturated)
		else $error("zero w result not cleared");

	// a clamped result shows a bound on some coordinate
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			out_x == ppt_pkg::POS_LIMIT || out_x == ppt_pkg::NEG_LIMIT ||
			out_y == ppt_pkg::POS_LIMIT || out_y == ppt_pkg::NEG_LIMIT ||
			out_z == ppt_pkg::POS_LIMIT || out_z == ppt_pkg::NEG_LIMIT)
		else $error("saturated without a bound value");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// an accepted request moves into the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_q[0])
		else $error("accepted request lost");
`endif

endmodule

`default_nettype wire

[dv/point_transform_checker.sv]
`default_nettype none

module point_transform_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic signed [ppt_pkg::CW-1:0] point_x,
	input  wire logic signed [ppt_pkg::CW-1:0] point_y,
	input  wire logic signed [ppt_pkg::CW-1:0] point_z,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic signed [ppt_pkg::CW-1:0] out_x,
	input  wire logic signed [ppt_pkg::CW-1:0] out_y,
	input  wire logic signed [ppt_pkg::CW-1:0] out_z,
	input  wire logic                          w_zero,
	input  wire logic                          saturated,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic                          pready,
	input  wire logic [ppt_pkg::AW-1:0]        paddr,
	input  wire logic [ppt_pkg::DW-1:0]        pwdata,
	output int                                 mismatch_count,
	output int                                 results_pending,
	output int                                 results_seen,
	output int                                 wzero_seen,
	output int                                 sat_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW        = ppt_pkg::CW;
	localparam int DW        = ppt_pkg::DW;
	localparam int NREG      = ppt_pkg::NREG;
	localparam int FRAC_BITS = ppt_pkg::FRAC_BITS;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          wz;
		logic          sat;
	} projected_t;

	logic [DW-1:0] matrix_regs [NREG];
	projected_t    expected_points [$];

	function automatic logic [CW-1:0] coef(input int r, input int c);
		logic [DW-1:0] v;
		v = matrix_regs[r * 2 + c / 2];
		return (c % 2 == 1) ? v[63:32] : v[31:0];
	endfunction

	// Magnitude and sign of a two's complement word
	function automatic logic [CW-1:0] magnitude(input logic [CW-1:0] v, output logic neg);
		neg = v[CW-1];
		return neg ? -v : v;
	endfunction

	// Exact column sum as magnitude and sign, scale 2*FRAC_BITS
	function automatic logic [63:0] column_mag(input int c, input logic [CW-1:0] p [3],
			output logic neg);
		logic [63:0] pos, negs, mp, mc;
		logic        sp, sc;
		pos = '0;
		negs = '0;
		for (int r = 0; r < 3; r++) begin
			mp = 64'(magnitude(p[r], sp));
			mc = 64'(magnitude(coef(r, c), sc));
			if (sp != sc) negs += mp * mc;
			else pos += mp * mc;
		end
		mc = 64'(magnitude(coef(3, c), sc)) << FRAC_BITS;
		if (sc) negs += mc;
		else pos += mc;
		neg = (pos < negs);
		return neg ? negs - pos : pos - negs;
	endfunction

	function automatic logic [CW-1:0] divide_clamped(input logic [63:0] num, input logic nneg,
			input logic [63:0] den, input logic dneg, inout logic sat);
		logic [127:0] q, limit;
		logic         neg;
		neg = nneg != dneg;
		q = ({64'b0, num} << FRAC_BITS) / {64'b0, den};
		limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > limit) begin
			q = limit;
			sat = 1'b1;
		end
		return neg ? -q[CW-1:0] : q[CW-1:0];
	endfunction

	function automatic projected_t project_point(input logic [CW-1:0] px,
			input logic [CW-1:0] py, input logic [CW-1:0] pz);
		logic [CW-1:0] p [3];
		logic [63:0]   wmag, cm;
		logic          wneg, cneg, sat;
		projected_t    r;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		sat = 1'b0;
		r = '0;
		wmag = column_mag(3, p, wneg);
		if (wmag == 0) begin
			r.wz = 1'b1;
			return r;
		end
		cm = column_mag(0, p, cneg);
		r.x = divide_clamped(cm, cneg, wmag, wneg, sat);
		cm = column_mag(1, p, cneg);
		r.y = divide_clamped(cm, cneg, wmag, wneg, sat);
		cm = column_mag(2, p, cneg);
		r.z = divide_clamped(cm, cneg, wmag, wneg, sat);
		r.sat = sat;
		return r;
	endfunction

	assign results_pending = expected_points.size();

	// Track matrix writes, predict accepted points, compare results
	always @(posedge clk or negedge arst_n) begin
		projected_t e;
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++)
				matrix_regs[i] = ppt_pkg::reset_value(ppt_pkg::reg_idx_t'(i));
			expected_points.delete();
			mismatch_count <= 0;
			results_seen <= 0;
			wzero_seen <= 0;
			sat_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (w_zero) wzero_seen <= wzero_seen + 1;
				if (saturated) sat_seen <= sat_seen + 1;
				if (expected_points.size() == 0) begin
					if (mismatch_count < 10)
						$display("ERROR: result with no request pending: %h %h %h", out_x,
							out_y, out_z);
					mismatch_count <= mismatch_count + 1;
				end else begin
					e = expected_points.pop_front();
					if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
							w_zero !== e.wz || saturated !== e.sat) begin
						if (mismatch_count < 10)
							$display({"ERROR: exp x=%h y=%h z=%h wz=%b sat=%b, ",
								"got x=%h y=%h z=%h wz=%b sat=%b"},
								e.x, e.y, e.z, e.wz, e.sat, out_x, out_y, out_z, w_zero,
								saturated);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				expected_points.push_back(project_point(point_x, point_y, point_z));
			if (psel && penable && pwrite && pready)
				matrix_regs[paddr[5:3]] = pwdata;
		end
	end

endmodule

`default_nettype wire

[dv/projective_point_transform_test.sv]
`default_nettype none

module projective_point_transform_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW          = ppt_pkg::CW;
	localparam int AW          = ppt_pkg::AW;
	localparam int DW          = ppt_pkg::DW;
	localparam int NREG        = ppt_pkg::NREG;
	localparam int STALL_LIMIT = 5000;

	logic                 clk, arst_n;
	logic                 in_valid, in_ready, out_valid, out_ready;
	logic signed [CW-1:0] point_x, point_y, point_z, out_x, out_y, out_z;
	logic                 w_zero, saturated;
	logic                 psel, penable, pwrite, pready;
	logic [AW-1:0]        paddr;
	logic [DW-1:0]        pwdata, prdata;
	int                   mismatch_count, results_pending, results_seen;
	int                   wzero_seen, sat_seen;
	int                   send_idle_pct, recv_idle_pct, idle_cycles, points_sent;

	projective_point_transform dut (.*);

	point_transform_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Randomly throttle the result side
	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without progress", idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		points_sent++;
	endtask

	// Hold off until the pipeline has drained
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input ppt_pkg::reg_idx_t idx, input logic [DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_matrix(input logic [CW-1:0] m [16]);
		for (int i = 0; i < NREG; i++)
			write_reg(ppt_pkg::reg_idx_t'(i), {m[i / 2 * 4 + (i % 2) * 2 + 1],
				m[i / 2 * 4 + (i % 2) * 2]});
	endtask

	function automatic logic [CW-1:0] rand_word(input int kind);
		case (kind)
			0: return $urandom();
			1: return CW'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
			2: return CW'($signed($urandom_range(2 * 1024)) - 1024);
			default: begin
				case ($urandom_range(3))
					0: return ppt_pkg::POS_LIMIT;
					1: return ppt_pkg::NEG_LIMIT;
					2: return 32'h0001_0000;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	// Pick a matrix shape: identity with a random w term, affine, perspective, random, or w always zero
	task automatic random_matrix(input int shape);
		logic [CW-1:0] m [16];
		int            k;
		for (int i = 0; i < 16; i++) begin
			k = $urandom_range(9) == 0 ? 3 : $urandom_range(1, 2);
			m[i] = (shape == 3) ? rand_word($urandom_range(1) ? 0 : k) : rand_word(k);
			if (shape == 0) m[i] = (i % 5 == 0) ? 32'h0001_0000 : '0;
			if (shape != 3 && i == 15) m[i] = rand_word(1) | 32'h0000_1000;
			if ((shape == 1 || shape == 0) && (i % 4 == 3) && i != 15) m[i] = '0;
			if (shape == 4 && (i % 4 == 3)) m[i] = '0;
		end
		load_matrix(m);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(4))
			0: return rand_word(0);
			1: return rand_word(3);
			2: return rand_word(2);
			default: return rand_word(1);
		endcase
	endfunction

	initial begin
		logic [CW-1:0] m [16];
		arst_n = 0;
		in_valid = 0;
		point_x = 0;
		point_y = 0;
		point_z = 0;
		out_ready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		idle_cycles = 0;
		points_sent = 0;
		send_idle_pct = 11;
		recv_idle_pct = 45;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity matrix from reset: extremes of the coordinates
		send_point('0, '0, '0);
		send_point(ppt_pkg::POS_LIMIT, ppt_pkg::NEG_LIMIT, 32'h0001_0000);
		send_point(ppt_pkg::NEG_LIMIT, ppt_pkg::POS_LIMIT, 32'hFFFF_0000);
		send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
		send_point(32'hAAAA_5555, 32'h1234_5678, ppt_pkg::NEG_LIMIT);
		drain();

		// Tiny w term: every nonzero quotient saturates
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0001_0000 : '0;
		m[15] = 32'h0000_0001;
		load_matrix(m);
		send_point(32'h0001_0000, 32'hFFFF_0000, '0);
		send_point(ppt_pkg::POS_LIMIT, ppt_pkg::NEG_LIMIT, ppt_pkg::POS_LIMIT);
		send_point('0, '0, '0);
		drain();

		// Extreme coefficients everywhere, w of either sign
		for (int i = 0; i < 16; i++)
			m[i] = (i % 2 == 0) ? ppt_pkg::NEG_LIMIT : ppt_pkg::POS_LIMIT;
		load_matrix(m);
		send_point(ppt_pkg::POS_LIMIT, ppt_pkg::POS_LIMIT, ppt_pkg::POS_LIMIT);
		send_point(ppt_pkg::NEG_LIMIT, ppt_pkg::NEG_LIMIT, ppt_pkg::NEG_LIMIT);
		send_point(32'h0001_0000, ppt_pkg::NEG_LIMIT, 32'h0000_0001);
		drain();

		// All-zero matrix: w is always zero
		for (int i = 0; i < 16; i++) m[i] = '0;
		load_matrix(m);
		send_point(ppt_pkg::POS_LIMIT, 32'h0001_0000, ppt_pkg::NEG_LIMIT);
		send_point('0, '0, '0);
		drain();

		// W cancels out for one point: x*M03 + M33 = 0
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0001_0000 : '0;
		m[3] = 32'h0001_0000;
		m[15] = 32'hFFFF_0000;
		load_matrix(m);
		send_point(32'h0001_0000, 32'h0003_0000, 32'h0007_0000);
		send_point(32'h0002_0000, 32'h0003_0000, 32'h0007_0000);
		send_point(32'h0001_8000, ppt_pkg::POS_LIMIT, ppt_pkg::NEG_LIMIT);
		drain();

		// Random part in three idling phases, new matrix every few dozen points
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 45 : 0;
			recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 11 : 0;
			for (int blk = 0; blk < 6; blk++) begin
				random_matrix($urandom_range(9) == 0 ? 4 : $urandom_range(3));
				for (int i = 0; i < 40; i++) send_point(rand_coord(), rand_coord(), rand_coord());
				drain();
			end
		end

		in_valid <= 1'b0;
		while (results_pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d points over %0d results, %0d with w zero, %0d saturated,",
			points_sent, results_seen, wzero_seen, sat_seen);
		$display("with identity, affine, perspective, random and degenerate matrices.");
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
